### rtl/tfe_pkg.sv
// ----------------------------------------------------------------------------
// Terminator framer package
// Types, register indexes, result kinds and reset values shared by the
// terminator framer and its head-match unit.
// ----------------------------------------------------------------------------
package tfe_pkg;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESOLVE,
		ST_FLUSH,
		ST_EOS
	} state_t;

	// Decision taken at the head of the pending window in one step.
	typedef enum logic [1:0] {
		ACT_STOP,
		ACT_REPLACE,
		ACT_DONE,
		ACT_BYTE
	} action_t;

	// Configuration register set.
	typedef struct packed {
		logic [2:0]  term_length;
		logic [31:0] term_pattern;
		logic        escape_enable;
		logic [2:0]  escape_length;
		logic [31:0] escape_pattern;
		logic [7:0]  replace_byte;
	} cfg_t;

	// Register indexes on the write port.
	localparam logic [2:0] REG_TERM_LENGTH    = 3'd0;
	localparam logic [2:0] REG_TERM_PATTERN   = 3'd1;
	localparam logic [2:0] REG_ESCAPE_ENABLE  = 3'd2;
	localparam logic [2:0] REG_ESCAPE_LENGTH  = 3'd3;
	localparam logic [2:0] REG_ESCAPE_PATTERN = 3'd4;
	localparam logic [2:0] REG_REPLACE_BYTE   = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Request types.
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// Register values after reset.
	localparam cfg_t CFG_RESET = '{
		term_length:    3'd2,
		term_pattern:   32'h0000_0A0D,
		escape_enable:  1'b0,
		escape_length:  3'd3,
		escape_pattern: 32'h0020_0A0D,
		replace_byte:   8'h0A
	};

	// Byte of a pattern register; bytes beyond the fourth read as zero.
	function automatic logic [7:0] pattern_byte(input logic [31:0] pat,
			input int unsigned idx);
		logic [7:0] res;
		res = 8'h00;
		if (idx < 4) begin
			res = pat[8*idx +: 8];
		end
		return res;
	endfunction

endpackage

### rtl/tfe_match.sv
// ----------------------------------------------------------------------------
// Terminator framer head-match unit
// Compares the pending window against the escape sequence and the
// terminator and decides what the next resolve step does.
// ----------------------------------------------------------------------------
module tfe_match #(
	parameter int MAX_PATTERN = 4
) (
	input  tfe_pkg::cfg_t                        cfg,
	input  logic [MAX_PATTERN-1:0][7:0]          window,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]     count,
	input  logic                                 flush_all,
	output tfe_pkg::action_t                     action,
	output logic [$clog2(MAX_PATTERN+1)-1:0]     drop
);

	localparam int CW = $clog2(MAX_PATTERN + 1);

	logic [CW-1:0]          tl;
	logic [CW-1:0]          el;
	logic [MAX_PATTERN-1:0] esc_eq;
	logic [MAX_PATTERN-1:0] term_eq;
	logic                   esc_full;
	logic                   term_full;
	logic                   esc_pre;
	logic                   term_pre;
	logic                   esc_part;
	logic                   term_part;

	// Effective lengths: zero counts as one, anything longer than the
	// window counts as the window size.
	always_comb begin
		if (cfg.term_length == 3'd0) begin
			tl = CW'(1);
		end else if (int'(cfg.term_length) > MAX_PATTERN) begin
			tl = CW'(MAX_PATTERN);
		end else begin
			tl = CW'(cfg.term_length);
		end
		if (cfg.escape_length == 3'd0) begin
			el = CW'(1);
		end else if (int'(cfg.escape_length) > MAX_PATTERN) begin
			el = CW'(MAX_PATTERN);
		end else begin
			el = CW'(cfg.escape_length);
		end
	end

	// Byte-wise compare of the window with both patterns.
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			esc_eq[i]  = window[i] == tfe_pkg::pattern_byte(cfg.escape_pattern, i);
			term_eq[i] = window[i] == tfe_pkg::pattern_byte(cfg.term_pattern, i);
		end
	end

	// Full matches over the pattern length and partial matches over the
	// bytes held so far.
	always_comb begin
		esc_full  = 1'b1;
		term_full = 1'b1;
		esc_pre   = 1'b1;
		term_pre  = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (CW'(i) < el && !esc_eq[i]) begin
				esc_full = 1'b0;
			end
			if (CW'(i) < tl && !term_eq[i]) begin
				term_full = 1'b0;
			end
			if (CW'(i) < count && !esc_eq[i]) begin
				esc_pre = 1'b0;
			end
			if (CW'(i) < count && !term_eq[i]) begin
				term_pre = 1'b0;
			end
		end
		esc_part  = cfg.escape_enable && !flush_all && count < el && esc_pre;
		term_part = !flush_all && count < tl && term_pre;
	end

	// Decision: escape first, then terminator unless an escape may still
	// follow, then hold back on a partial match, otherwise pass one byte.
	always_comb begin
		action = tfe_pkg::ACT_STOP;
		drop   = CW'(1);
		priority if (count == '0) begin
			action = tfe_pkg::ACT_STOP;
		end else if (cfg.escape_enable && count >= el && esc_full) begin
			action = tfe_pkg::ACT_REPLACE;
			drop   = el;
		end else if (count >= tl && term_full) begin
			if (esc_part) begin
				action = tfe_pkg::ACT_STOP;
			end else begin
				action = tfe_pkg::ACT_DONE;
				drop   = tl;
			end
		end else if (esc_part || term_part) begin
			action = tfe_pkg::ACT_STOP;
		end else begin
			action = tfe_pkg::ACT_BYTE;
			drop   = CW'(1);
		end
	end

endmodule

### rtl/terminator_framer_with_escape.sv
// ----------------------------------------------------------------------------
// Terminator framer with escape
// Cuts a byte stream into values ending at a configurable terminator, with
// optional replacement of an escape sequence by a single byte.
// ----------------------------------------------------------------------------
// Each accepted word is a data byte or an end-of-stream mark; a data byte is
// taken into a window of up to MAX_PATTERN pending bytes. A small sequencer
// then resolves the head of that window through one shared match unit, one
// step per cycle while the output side does not stall. Each result adds one
// resolve step. The last result of an item is held back by one step so that
// it can be flagged, and one more step releases it. At end of stream the
// pending bytes are flushed without holding back partial matches, the held
// result is released and a closing error word follows. The input is stalled
// until the sequencer returns to idle; the output register lets the next
// word be accepted while a result waits.
module terminator_framer_with_escape #(
	parameter int MAX_PATTERN = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        last
);

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int IW = $clog2(MAX_PATTERN);

	tfe_pkg::cfg_t   cfg_q;
	tfe_pkg::state_t state_q, state_d;

	logic [MAX_PATTERN-1:0][7:0] pend_q;
	logic [CW-1:0]               count_q;
	logic                        final_q;
	logic                        append_q;
	logic                        eos_q;
	logic [7:0]                  in_byte_q;

	logic       held_valid_q;
	logic [1:0] held_kind_q;
	logic [7:0] held_byte_q;

	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	tfe_pkg::action_t action;
	logic [CW-1:0]    drop;

	logic                        out_free;
	logic                        accept;
	logic                        emit_new;
	logic                        push_held;
	logic                        push_err;
	logic                        push_last;
	logic                        do_append;
	logic [1:0]                  new_kind;
	logic [7:0]                  new_byte;
	logic [MAX_PATTERN-1:0][7:0] shifted;
	logic [CW-1:0]               count_drop;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && (state_q == tfe_pkg::ST_IDLE);
	assign in_stall = state_q != tfe_pkg::ST_IDLE;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= tfe_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				tfe_pkg::REG_TERM_LENGTH:    cfg_q.term_length    <= wr_data[2:0];
				tfe_pkg::REG_TERM_PATTERN:   cfg_q.term_pattern   <= wr_data;
				tfe_pkg::REG_ESCAPE_ENABLE:  cfg_q.escape_enable  <= wr_data[0];
				tfe_pkg::REG_ESCAPE_LENGTH:  cfg_q.escape_length  <= wr_data[2:0];
				tfe_pkg::REG_ESCAPE_PATTERN: cfg_q.escape_pattern <= wr_data;
				tfe_pkg::REG_REPLACE_BYTE:   cfg_q.replace_byte   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// Shared head-match unit.
	tfe_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.cfg      (cfg_q),
		.window   (pend_q),
		.count    (count_q),
		.flush_all(final_q),
		.action   (action),
		.drop     (drop)
	);

	// Window after dropping the matched head bytes.
	always_comb begin
		shifted = pend_q;
		for (int k = 1; k <= MAX_PATTERN; k++) begin
			if (drop == CW'(k)) begin
				for (int i = 0; i + k < MAX_PATTERN; i++) begin
					shifted[i] = pend_q[i + k];
				end
			end
		end
		count_drop = (drop >= count_q) ? '0 : count_q - drop;
	end

	// Result produced by the current resolve step.
	always_comb begin
		new_kind = tfe_pkg::KIND_BYTE;
		new_byte = 8'h00;
		unique case (action)
			tfe_pkg::ACT_REPLACE: new_byte = cfg_q.replace_byte;
			tfe_pkg::ACT_DONE:    new_kind = tfe_pkg::KIND_DONE;
			tfe_pkg::ACT_BYTE:    new_byte = pend_q[0];
			tfe_pkg::ACT_STOP:    new_byte = 8'h00;
		endcase
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfe_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = tfe_pkg::ST_RESOLVE;
				end
			end
			tfe_pkg::ST_RESOLVE: begin
				if (out_free && action == tfe_pkg::ACT_STOP && !append_q) begin
					if (eos_q) begin
						state_d = tfe_pkg::ST_EOS;
					end else if (held_valid_q) begin
						state_d = tfe_pkg::ST_FLUSH;
					end else begin
						state_d = tfe_pkg::ST_IDLE;
					end
				end
			end
			tfe_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = tfe_pkg::ST_IDLE;
				end
			end
			tfe_pkg::ST_EOS: begin
				if (out_free && !held_valid_q) begin
					state_d = tfe_pkg::ST_IDLE;
				end
			end
			default: state_d = tfe_pkg::ST_IDLE;
		endcase
	end

	// Control strobes of the sequencer.
	always_comb begin
		emit_new  = 1'b0;
		push_held = 1'b0;
		push_err  = 1'b0;
		push_last = 1'b0;
		do_append = 1'b0;
		unique case (state_q)
			tfe_pkg::ST_RESOLVE: begin
				if (out_free) begin
					if (action != tfe_pkg::ACT_STOP) begin
						emit_new  = 1'b1;
						push_held = held_valid_q;
					end else begin
						do_append = append_q;
					end
				end
			end
			tfe_pkg::ST_FLUSH: begin
				push_held = out_free;
				push_last = 1'b1;
			end
			tfe_pkg::ST_EOS: begin
				if (out_free) begin
					if (held_valid_q) begin
						push_held = 1'b1;
					end else begin
						push_err  = 1'b1;
						push_last = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer state and item flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tfe_pkg::ST_IDLE;
			final_q  <= 1'b0;
			append_q <= 1'b0;
			eos_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				eos_q <= req_type == tfe_pkg::REQ_END;
				if (req_type == tfe_pkg::REQ_END) begin
					final_q  <= 1'b1;
					append_q <= 1'b0;
				end else if (count_q == CW'(MAX_PATTERN)) begin
					final_q  <= 1'b1;
					append_q <= 1'b1;
				end else begin
					final_q  <= 1'b0;
					append_q <= 1'b0;
				end
			end else if (do_append) begin
				final_q  <= 1'b0;
				append_q <= 1'b0;
			end
		end
	end

	// Pending window: append on accept or after a full flush, shift when a result is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && req_type == tfe_pkg::REQ_DATA
				&& count_q != CW'(MAX_PATTERN)) begin
			count_q <= count_q + CW'(1);
		end else if (do_append) begin
			count_q <= count_q + CW'(1);
		end else if (emit_new) begin
			count_q <= count_drop;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_byte_q <= data_byte;
			if (req_type == tfe_pkg::REQ_DATA && count_q != CW'(MAX_PATTERN)) begin
				pend_q[count_q[IW-1:0]] <= data_byte;
			end
		end else if (do_append) begin
			pend_q[count_q[IW-1:0]] <= in_byte_q;
		end else if (emit_new) begin
			pend_q <= shifted;
		end
	end

	// Held result: kept back one step so that the last word can be flagged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (emit_new) begin
			held_valid_q <= 1'b1;
		end else if (push_held) begin
			held_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_new) begin
			held_kind_q <= new_kind;
			held_byte_q <= new_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_held || push_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_held) begin
			out_kind_q <= held_kind_q;
			out_byte_q <= held_byte_q;
			out_last_q <= push_last;
		end else if (push_err) begin
			out_kind_q <= tfe_pkg::KIND_ERROR;
			out_byte_q <= 8'h00;
			out_last_q <= 1'b1;
		end
	end

endmodule
